[src/ffsa_pkg.sv]
// Shared types, widths and codes for the first-fit segment allocator.
// Used by ffsa_alu, ffsa_table and first_fit_segment_allocator; no dependencies.
`timescale 1ns / 1ps

package ffsa_pkg;

    // Table depth and offset width
    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_W       = 32;
    localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    // Word field widths
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 3;
    localparam int S_TDATA_W    = ((CMD_W + 2 * ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((STATUS_W + 2 * ADDR_W + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd4;

    // Shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // One table entry
    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] length;
        logic [ADDR_W-1:0] start;
    } seg_entry_t;

    // Table write request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        seg_entry_t       data;
    } tbl_wr_t;

    // Shared unit result
    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              borrow;
        logic              zero;
    } alu_res_t;

endpackage

[src/ffsa_alu.sv]
// Shared add/subtract/compare unit of the allocator.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_alu (
    input  logic                      op,
    input  logic [ffsa_pkg::ADDR_W-1:0] a,
    input  logic [ffsa_pkg::ADDR_W-1:0] b,
    output ffsa_pkg::alu_res_t        res
);

    logic [ffsa_pkg::ADDR_W:0] wide;

    // Add or subtract with carry out; borrow flags a < b on subtract
    always_comb
    begin
        if (op == ffsa_pkg::ALU_SUB)
        begin
            wide = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            wide = {1'b0, a} + {1'b0, b};
        end
        res.sum    = wide[ffsa_pkg::ADDR_W-1:0];
        res.borrow = (op == ffsa_pkg::ALU_SUB) && wide[ffsa_pkg::ADDR_W];
        res.zero   = (wide[ffsa_pkg::ADDR_W-1:0] == '0);
    end

endmodule

[src/ffsa_table.sv]
// Segment table memory: one write port, one registered read port.
// Entry 0 reads as a free total_size segment from reset or rebuild until written.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rebuild,
    input  logic [ffsa_pkg::ADDR_W-1:0] total_size,
    input  logic [ffsa_pkg::IDX_W-1:0]  rd_addr,
    output ffsa_pkg::seg_entry_t        rd_data,
    input  ffsa_pkg::tbl_wr_t           wr
);

    ffsa_pkg::seg_entry_t mem [ffsa_pkg::MAX_SEGMENTS];
    ffsa_pkg::seg_entry_t rd_mem_reg;
    logic                 base_reg;
    logic                 base_next;
    logic                 base_hit_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_mem_reg <= mem[rd_addr];
    end

    // Track whether entry 0 still holds the rebuilt single free segment
    always_comb
    begin
        base_next = base_reg;
        if (wr.we && (wr.addr == '0))
        begin
            base_next = 1'b0;
        end
        if (rebuild)
        begin
            base_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= 1'b1;
            base_hit_reg <= 1'b0;
        end
        else
        begin
            base_reg     <= base_next;
            base_hit_reg <= base_reg && (rd_addr == '0);
        end
    end

    // Substitute the rebuilt entry on a hit
    always_comb
    begin
        if (base_hit_reg)
        begin
            rd_data.used   = 1'b0;
            rd_data.length = total_size;
            rd_data.start  = '0;
        end
        else
        begin
            rd_data = rd_mem_reg;
        end
    end

endmodule

[src/first_fit_segment_allocator.sv]
// First-fit segment allocator: top level with command sequencer.
// Depends on ffsa_pkg, ffsa_alu and ffsa_table.
//
// Usage
//   s_* channel takes one command word: allocate, free by offset or clear.
//   m_* channel returns one result word per command: status, granted offset
//   and the bytes still free. cfg_* writes total_size; the table is then
//   rebuilt as one free segment. A config write is taken only while idle
//   and has priority over a waiting command word.
//   The sequencer walks the table one entry per cycle through the single
//   table read port, then shifts entries one per cycle to open or close a
//   slot, with one shared add/subtract unit doing the compares and sums on
//   table entries and byte counts. One command is in work at a time and
//   s_tready is high only while the sequencer is idle.
//   The result sits in an output register; a new command is accepted while
//   it waits. If the receiver stalls, the next result holds in the
//   sequencer until the output register frees up.
//   Reset gives one free segment of 65536 bytes; no clearing pass is needed.
`timescale 1ns / 1ps

module first_fit_segment_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    // command[1:0], request_size[33:2], block_offset[65:34], zero pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ffsa_pkg::S_TDATA_W-1:0]  s_tdata,
    // status[2:0], granted_offset[34:3], free_space[66:35], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffsa_pkg::M_TDATA_W-1:0]  m_tdata,
    // total_size
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffsa_pkg::ADDR_W-1:0]     cfg_data
);

    localparam int AW = ffsa_pkg::ADDR_W;
    localparam int IW = ffsa_pkg::IDX_W;
    localparam int CW = ffsa_pkg::CNT_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_SHUP = 4'd2;
    localparam logic [3:0] S_SPLA = 4'd3;
    localparam logic [3:0] S_SPLB = 4'd4;
    localparam logic [3:0] S_BUMP = 4'd5;
    localparam logic [3:0] S_FNXT = 4'd6;
    localparam logic [3:0] S_FPRV = 4'd7;
    localparam logic [3:0] S_FSUM = 4'd8;
    localparam logic [3:0] S_SHDN = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0]                     state_reg, state_next;
    logic [ffsa_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [AW-1:0]                  size_reg, size_next;
    logic [AW-1:0]                  off_reg, off_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [IW-1:0]                  hit_reg, hit_next;
    logic [AW-1:0]                  ent_start_reg, ent_start_next;
    logic [AW-1:0]                  ent_len_reg, ent_len_next;
    logic [AW-1:0]                  acc_reg, acc_next;
    logic                           nmerge_reg, nmerge_next;
    logic                           pmerge_reg, pmerge_next;
    logic [AW-1:0]                  nlen_reg, nlen_next;
    logic [AW-1:0]                  plen_reg, plen_next;
    logic [AW-1:0]                  pstart_reg, pstart_next;
    logic [1:0]                     shift_r_reg, shift_r_next;
    logic [ffsa_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [AW-1:0]                  granted_reg, granted_next;
    logic [CW-1:0]                  seg_count_reg, seg_count_next;
    logic [AW-1:0]                  used_bytes_reg, used_bytes_next;
    logic [AW-1:0]                  total_size_reg, total_size_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [ffsa_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [AW-1:0]                  m_granted_reg, m_granted_next;
    logic [AW-1:0]                  m_free_reg, m_free_next;

    logic                           s_accept;
    logic                           cfg_accept;
    logic                           rebuild;
    logic [IW-1:0]                  rd_addr;
    ffsa_pkg::seg_entry_t           rd_data;
    ffsa_pkg::tbl_wr_t              tbl_wr;
    logic                           alu_op;
    logic [AW-1:0]                  alu_a;
    logic [AW-1:0]                  alu_b;
    ffsa_pkg::alu_res_t             alu_res;

    logic [CW-1:0]                  idx_inc;
    logic [IW-1:0]                  hit_inc;
    logic [IW-1:0]                  hit_dec;
    logic [IW-1:0]                  tgt_idx;
    logic [1:0]                     merge_r;
    logic [CW-1:0]                  shdn_src;

    // Handshakes
    assign cfg_ready  = (state_reg == S_IDLE);
    assign s_tready   = (state_reg == S_IDLE) && !cfg_valid;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(ffsa_pkg::M_TDATA_W - ffsa_pkg::STATUS_W - 2 * AW){1'b0}},
                       m_free_reg, m_granted_reg, m_status_reg};

    // Index arithmetic
    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign hit_inc  = hit_reg + IW'(1);
    assign hit_dec  = hit_reg - IW'(1);
    assign tgt_idx  = pmerge_reg ? hit_dec : hit_reg;
    assign merge_r  = {1'b0, nmerge_reg} + {1'b0, pmerge_reg};
    assign shdn_src = CW'(tgt_idx) + CW'(1) + CW'(merge_r);

    ffsa_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    ffsa_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rebuild    (rebuild),
        .total_size (total_size_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr         (tbl_wr)
    );

    // Operand select for the shared unit
    always_comb
    begin
        alu_op = ffsa_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_SCAN:
            begin
                alu_op = ffsa_pkg::ALU_SUB;
                if (cmd_reg == ffsa_pkg::CMD_ALLOC)
                begin
                    alu_a = rd_data.length;
                    alu_b = size_reg;
                end
                else
                begin
                    alu_a = rd_data.start;
                    alu_b = off_reg;
                end
            end
            S_SPLA:
            begin
                alu_a = ent_start_reg;
                alu_b = size_reg;
            end
            S_BUMP:
            begin
                alu_a = used_bytes_reg;
                alu_b = size_reg;
            end
            S_FNXT:
            begin
                alu_op = ffsa_pkg::ALU_SUB;
                alu_a  = used_bytes_reg;
                alu_b  = ent_len_reg;
            end
            S_FPRV:
            begin
                alu_a = ent_len_reg;
                alu_b = nmerge_reg ? nlen_reg : '0;
            end
            S_FSUM:
            begin
                alu_a = acc_reg;
                alu_b = pmerge_reg ? plen_reg : '0;
            end
            S_RESP:
            begin
                alu_op = ffsa_pkg::ALU_SUB;
                alu_a  = total_size_reg;
                alu_b  = used_bytes_reg;
            end
            default:
            begin
                alu_op = ffsa_pkg::ALU_ADD;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        size_next       = size_reg;
        off_next        = off_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        ent_start_next  = ent_start_reg;
        ent_len_next    = ent_len_reg;
        acc_next        = acc_reg;
        nmerge_next     = nmerge_reg;
        pmerge_next     = pmerge_reg;
        nlen_next       = nlen_reg;
        plen_next       = plen_reg;
        pstart_next     = pstart_reg;
        shift_r_next    = shift_r_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        seg_count_next  = seg_count_reg;
        used_bytes_next = used_bytes_reg;
        total_size_next = total_size_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_granted_next  = m_granted_reg;
        m_free_next     = m_free_reg;
        rebuild         = 1'b0;
        rd_addr         = idx_reg;
        tbl_wr.we       = 1'b0;
        tbl_wr.addr     = idx_reg;
        tbl_wr.data     = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (cfg_accept)
                begin
                    // Rebuild the table at the new size
                    total_size_next = cfg_data;
                    seg_count_next  = CW'(1);
                    used_bytes_next = '0;
                    rebuild         = 1'b1;
                end
                else if (s_accept)
                begin
                    cmd_next     = s_tdata[1:0];
                    size_next    = s_tdata[ffsa_pkg::CMD_W +: AW];
                    off_next     = s_tdata[ffsa_pkg::CMD_W + AW +: AW];
                    idx_next     = '0;
                    status_next  = ffsa_pkg::ST_OK;
                    granted_next = '0;
                    unique case (s_tdata[1:0])
                        ffsa_pkg::CMD_ALLOC:
                        begin
                            if (s_tdata[ffsa_pkg::CMD_W +: AW] == '0)
                            begin
                                status_next = ffsa_pkg::ST_ZERO_SIZE;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ffsa_pkg::CMD_FREE:
                        begin
                            state_next = S_SCAN;
                        end
                        ffsa_pkg::CMD_CLEAR:
                        begin
                            seg_count_next  = CW'(1);
                            used_bytes_next = '0;
                            rebuild         = 1'b1;
                            state_next      = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Examine entry idx, prefetch the next one
                idx_next = idx_inc[IW-1:0];
                rd_addr  = idx_inc[IW-1:0];
                if (cmd_reg == ffsa_pkg::CMD_ALLOC)
                begin
                    if (!rd_data.used && !alu_res.borrow)
                    begin
                        if (alu_res.zero)
                        begin
                            // Exact fit: mark used in place
                            tbl_wr.we        = 1'b1;
                            tbl_wr.addr      = idx_reg;
                            tbl_wr.data      = rd_data;
                            tbl_wr.data.used = 1'b1;
                            granted_next     = rd_data.start;
                            state_next       = S_BUMP;
                        end
                        else if (seg_count_reg == CW'(ffsa_pkg::MAX_SEGMENTS))
                        begin
                            status_next = ffsa_pkg::ST_TABLE_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            // Split: open a slot after idx
                            hit_next       = idx_reg;
                            ent_start_next = rd_data.start;
                            acc_next       = alu_res.sum;
                            granted_next   = rd_data.start;
                            if (idx_inc < seg_count_reg)
                            begin
                                idx_next   = IW'(seg_count_reg - CW'(1));
                                rd_addr    = IW'(seg_count_reg - CW'(1));
                                state_next = S_SHUP;
                            end
                            else
                            begin
                                state_next = S_SPLA;
                            end
                        end
                    end
                    else if (idx_inc >= seg_count_reg)
                    begin
                        status_next = ffsa_pkg::ST_NO_SPACE;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    if (rd_data.used && alu_res.zero)
                    begin
                        hit_next       = idx_reg;
                        ent_start_next = rd_data.start;
                        ent_len_next   = rd_data.length;
                        state_next     = S_FNXT;
                    end
                    else if (idx_inc >= seg_count_reg)
                    begin
                        status_next = ffsa_pkg::ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end
            end

            S_SHUP:
            begin
                // Move entry idx up by one, walking down
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = idx_reg + IW'(1);
                tbl_wr.data = rd_data;
                if (idx_reg == hit_inc)
                begin
                    state_next = S_SPLA;
                end
                else
                begin
                    idx_next = idx_reg - IW'(1);
                    rd_addr  = idx_reg - IW'(1);
                end
            end

            S_SPLA:
            begin
                // Write the free remainder behind the carved block
                tbl_wr.we          = 1'b1;
                tbl_wr.addr        = hit_inc;
                tbl_wr.data.used   = 1'b0;
                tbl_wr.data.length = acc_reg;
                tbl_wr.data.start  = alu_res.sum;
                state_next         = S_SPLB;
            end

            S_SPLB:
            begin
                tbl_wr.we          = 1'b1;
                tbl_wr.addr        = hit_reg;
                tbl_wr.data.used   = 1'b1;
                tbl_wr.data.length = size_reg;
                tbl_wr.data.start  = ent_start_reg;
                seg_count_next     = seg_count_reg + CW'(1);
                state_next         = S_BUMP;
            end

            S_BUMP:
            begin
                used_bytes_next = alu_res.sum;
                state_next      = S_RESP;
            end

            S_FNXT:
            begin
                // Entry after the freed one is in rd_data
                nmerge_next     = (CW'(hit_reg) + CW'(1) < seg_count_reg) && !rd_data.used;
                nlen_next       = rd_data.length;
                used_bytes_next = alu_res.sum;
                rd_addr         = hit_dec;
                state_next      = S_FPRV;
            end

            S_FPRV:
            begin
                // Entry before the freed one is in rd_data
                pmerge_next = (hit_reg != '0) && !rd_data.used;
                plen_next   = rd_data.length;
                pstart_next = rd_data.start;
                acc_next    = alu_res.sum;
                state_next  = S_FSUM;
            end

            S_FSUM:
            begin
                // Write the merged free segment, then close the gap
                tbl_wr.we          = 1'b1;
                tbl_wr.addr        = tgt_idx;
                tbl_wr.data.used   = 1'b0;
                tbl_wr.data.length = alu_res.sum;
                tbl_wr.data.start  = pmerge_reg ? pstart_reg : ent_start_reg;
                shift_r_next       = merge_r;
                if ((merge_r != 2'd0) && (shdn_src < seg_count_reg))
                begin
                    idx_next   = shdn_src[IW-1:0];
                    rd_addr    = shdn_src[IW-1:0];
                    state_next = S_SHDN;
                end
                else
                begin
                    seg_count_next = seg_count_reg - CW'(merge_r);
                    state_next     = S_RESP;
                end
            end

            S_SHDN:
            begin
                // Move entry idx down by the number of merged entries
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = idx_reg - IW'(shift_r_reg);
                tbl_wr.data = rd_data;
                if (idx_inc < seg_count_reg)
                begin
                    idx_next = idx_inc[IW-1:0];
                    rd_addr  = idx_inc[IW-1:0];
                end
                else
                begin
                    seg_count_next = seg_count_reg - CW'(shift_r_reg);
                    state_next     = S_RESP;
                end
            end

            S_RESP:
            begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    m_status_next  = status_reg;
                    m_granted_next = granted_reg;
                    m_free_next    = alu_res.sum;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seg_count_reg  <= CW'(1);
            used_bytes_reg <= '0;
            total_size_reg <= AW'(65536);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seg_count_reg  <= seg_count_next;
            used_bytes_reg <= used_bytes_next;
            total_size_reg <= total_size_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        size_reg      <= size_next;
        off_reg       <= off_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        ent_start_reg <= ent_start_next;
        ent_len_reg   <= ent_len_next;
        acc_reg       <= acc_next;
        nmerge_reg    <= nmerge_next;
        pmerge_reg    <= pmerge_next;
        nlen_reg      <= nlen_next;
        plen_reg      <= plen_next;
        pstart_reg    <= pstart_next;
        shift_r_reg   <= shift_r_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        m_status_reg  <= m_status_next;
        m_granted_reg <= m_granted_next;
        m_free_reg    <= m_free_next;
    end

`ifndef ASSERT_OFF
    // Segment count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (seg_count_reg != '0) && (seg_count_reg <= CW'(ffsa_pkg::MAX_SEGMENTS)))
        else $error("segment count out of range");

    // Table writes never land beyond one past the last live entry
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.we |-> (CW'(tbl_wr.addr) <= seg_count_reg))
        else $error("table write beyond live entries");

    // An accepted command always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg != S_IDLE))
        else $error("command accepted without starting work");

    // A granted offset is reported only with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_status_reg != ffsa_pkg::ST_OK)) |-> (m_granted_reg == '0))
        else $error("granted offset on failed command");
`endif

endmodule

[tb/tb_first_fit_segment_allocator.sv]
// Self-checking testbench for first_fit_segment_allocator: directed rows, then random
// command streams over several total_size settings, checked against a segment-table predictor.
// Depends on ffsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;

    import ffsa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 1000000;
    localparam int               SETTLE      = 80;
    localparam int               PHASES      = 9;
    localparam int               PHASE_ITEMS = 100;
    localparam int               DIR_ROWS    = 22;

    typedef logic [ADDR_W-1:0] addr_t;

    // One result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        addr_t               granted;
        addr_t               free_space;
    } seg_result_t;

    // One directed row; want is used only where typed is set
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        addr_t            req;
        addr_t            off;
        logic             typed;
        seg_result_t      want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    addr_t                cfg_data;

    // Predictor copy of the segment table
    addr_t seg_begin [MAX_SEGMENTS];
    addr_t seg_len   [MAX_SEGMENTS];
    logic  seg_taken [MAX_SEGMENTS];
    int    seg_total;
    addr_t bytes_held;
    addr_t range_size;

    seg_result_t expected_results[$];
    int          n_errors;
    int          n_checked;
    int          n_settings;
    int          status_seen[8];
    int          cycle_count;
    int          src_idle_pct;
    int          snk_idle_pct;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_ALLOC,  32'd0,          32'd0,          1'b1, '{ST_ZERO_SIZE,  32'd0,   32'd65536}},
        '{CMD_ALLOC,  32'd65537,      32'd0,          1'b1, '{ST_NO_SPACE,   32'd0,   32'd65536}},
        '{CMD_ALLOC,  32'hFFFF_FFFF,  32'h0,          1'b1, '{ST_NO_SPACE,   32'd0,   32'd65536}},
        '{CMD_FREE,   32'd0,          32'd0,          1'b1, '{ST_NOT_FOUND,  32'd0,   32'd65536}},
        '{CMD_ALLOC,  32'd65536,      32'd0,          1'b1, '{ST_OK,         32'd0,   32'd0}},
        '{CMD_ALLOC,  32'd1,          32'd0,          1'b1, '{ST_NO_SPACE,   32'd0,   32'd0}},
        '{CMD_FREE,   32'd0,          32'd0,          1'b1, '{ST_OK,         32'd0,   32'd65536}},
        '{CMD_ALLOC,  32'd100,        32'd0,          1'b1, '{ST_OK,         32'd0,   32'd65436}},
        '{CMD_ALLOC,  32'd200,        32'd0,          1'b1, '{ST_OK,         32'd100, 32'd65236}},
        '{CMD_ALLOC,  32'd300,        32'd0,          1'b1, '{ST_OK,         32'd300, 32'd64936}},
        '{CMD_FREE,   32'd0,          32'hFFFF_FFFF,  1'b1, '{ST_NOT_FOUND,  32'd0,   32'd64936}},
        '{CMD_FREE,   32'd0,          32'd100,        1'b0, '0},
        '{CMD_FREE,   32'd0,          32'd100,        1'b0, '0},
        '{CMD_ALLOC,  32'd50,         32'd0,          1'b0, '0},
        '{CMD_FREE,   32'd0,          32'd0,          1'b0, '0},
        '{CMD_FREE,   32'd0,          32'd300,        1'b0, '0},
        '{CMD_UNUSED, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b0, '0},
        '{CMD_FREE,   32'd0,          32'd100,        1'b0, '0},
        '{CMD_CLEAR,  32'hA5A5_A5A5,  32'h5A5A_5A5A,  1'b1, '{ST_OK,         32'd0,   32'd65536}},
        '{CMD_ALLOC,  32'd1,          32'd0,          1'b1, '{ST_OK,         32'd0,   32'd65535}},
        '{CMD_UNUSED, 32'd0,          32'd0,          1'b0, '0},
        '{CMD_CLEAR,  32'd0,          32'd0,          1'b1, '{ST_OK,         32'd0,   32'd65536}}
    };

    first_fit_segment_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rebuild the table as one free segment over the whole range
    function automatic void rebuild_segments();
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            seg_begin[k] = '0;
            seg_len[k]   = '0;
            seg_taken[k] = 1'b0;
        end
        seg_len[0] = range_size;
        seg_total  = 1;
        bytes_held = '0;
    endfunction

    // Close the slot at idx by shifting later entries down
    function automatic void drop_segment(int idx);
        for (int k = idx; k + 1 < seg_total; k++)
        begin
            seg_begin[k] = seg_begin[k + 1];
            seg_len[k]   = seg_len[k + 1];
            seg_taken[k] = seg_taken[k + 1];
        end
        seg_total--;
    endfunction

    // Apply one command to the table copy and return the word it must produce
    function automatic seg_result_t predict_segment_result(logic [CMD_W-1:0] cmd, addr_t req,
                                                           addr_t off);
        seg_result_t res;
        int          hit;
        res.status  = ST_OK;
        res.granted = '0;
        hit         = -1;
        if (cmd == CMD_ALLOC)
        begin
            if (req == '0)
                res.status = ST_ZERO_SIZE;
            else
            begin
                for (int i = 0; i < seg_total; i++)
                    if (hit < 0 && !seg_taken[i] && seg_len[i] >= req)
                        hit = i;
                if (hit < 0)
                    res.status = ST_NO_SPACE;
                else if (seg_len[hit] == req)
                begin
                    seg_taken[hit] = 1'b1;
                    bytes_held     = bytes_held + req;
                    res.granted    = seg_begin[hit];
                end
                else if (seg_total >= MAX_SEGMENTS)
                    res.status = ST_TABLE_FULL;
                else
                begin
                    // split: open a slot behind hit for the remainder
                    for (int k = seg_total; k > hit; k--)
                    begin
                        seg_begin[k] = seg_begin[k - 1];
                        seg_len[k]   = seg_len[k - 1];
                        seg_taken[k] = seg_taken[k - 1];
                    end
                    seg_total++;
                    seg_taken[hit]     = 1'b1;
                    seg_len[hit]       = req;
                    seg_begin[hit + 1] = seg_begin[hit] + req;
                    seg_len[hit + 1]   = seg_len[hit + 1] - req;
                    seg_taken[hit + 1] = 1'b0;
                    bytes_held         = bytes_held + req;
                    res.granted        = seg_begin[hit];
                end
            end
        end
        else if (cmd == CMD_FREE)
        begin
            for (int i = 0; i < seg_total; i++)
                if (hit < 0 && seg_taken[i] && seg_begin[i] == off)
                    hit = i;
            if (hit < 0)
                res.status = ST_NOT_FOUND;
            else
            begin
                seg_taken[hit] = 1'b0;
                bytes_held     = bytes_held - seg_len[hit];
                // merge with the free neighbor on the right, then the left
                if (hit + 1 < seg_total && !seg_taken[hit + 1])
                begin
                    seg_len[hit] = seg_len[hit] + seg_len[hit + 1];
                    drop_segment(hit + 1);
                end
                if (hit > 0 && !seg_taken[hit - 1])
                begin
                    seg_len[hit - 1] = seg_len[hit - 1] + seg_len[hit];
                    drop_segment(hit);
                end
            end
        end
        else if (cmd == CMD_CLEAR)
            rebuild_segments();
        res.free_space = range_size - bytes_held;
        return res;
    endfunction

    // Offer one command word after a random gap; predict once it is taken
    task automatic send_word(logic [CMD_W-1:0] cmd, addr_t req, addr_t off, logic typed,
                             seg_result_t want);
        seg_result_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CMD_W - 2 * ADDR_W){1'b0}}, off, req, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_segment_result(cmd, req, off);
        expected_results.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Drop the command valid, wait for every result, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write total_size while idle; the table restarts as one free segment
    task automatic write_total(addr_t value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        range_size = value;
        rebuild_segments();
        n_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Pick one random command, mostly well-formed against the current table
    task automatic send_random(logic fill);
        int    r;
        int    pick;
        int    idx_list[$];
        addr_t max_small;
        addr_t size;
        r         = $urandom_range(99);
        max_small = fill ? addr_t'(3) : (range_size >> 4);
        if (max_small == '0)
            max_small = addr_t'(1);
        if (r < 2)
            send_word(CMD_UNUSED, $urandom(), $urandom(), 1'b0, '0);
        else if (r < 4)
            send_word(CMD_CLEAR, $urandom(), $urandom(), 1'b0, '0);
        else if (r < 7)
            send_word(CMD_ALLOC, '0, $urandom(), 1'b0, '0);
        else if (r < 10)
            send_word(CMD_ALLOC, $urandom(), $urandom(), 1'b0, '0);
        else if (r < 13)
            send_word(CMD_FREE, $urandom(), $urandom(), 1'b0, '0);
        else if (r < (fill ? 85 : 60))
        begin
            size = $urandom_range(max_small, 1);
            // now and then ask for exactly the length of a free segment
            if ($urandom_range(99) < 15)
            begin
                for (int i = 0; i < seg_total; i++)
                    if (!seg_taken[i] && seg_len[i] != '0)
                        idx_list.push_back(i);
                if (idx_list.size() != 0)
                    size = seg_len[idx_list[$urandom_range(idx_list.size() - 1)]];
            end
            send_word(CMD_ALLOC, size, $urandom(), 1'b0, '0);
        end
        else
        begin
            // free a used segment, sometimes any segment start at all
            for (int i = 0; i < seg_total; i++)
                if (seg_taken[i] || $urandom_range(99) < 20)
                    idx_list.push_back(i);
            if (idx_list.size() != 0)
            begin
                pick = idx_list[$urandom_range(idx_list.size() - 1)];
                send_word(CMD_FREE, $urandom(), seg_begin[pick], 1'b0, '0);
            end
            else
                send_word(CMD_FREE, $urandom(), $urandom(), 1'b0, '0);
        end
    endtask

    // Receiver stalls at random
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // Compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        seg_result_t got;
        seg_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tdata[STATUS_W-1:0];
            got.granted    = m_tdata[STATUS_W +: ADDR_W];
            got.free_space = m_tdata[STATUS_W + ADDR_W +: ADDR_W];
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: status %0d", got.status);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                n_checked++;
                status_seen[got.status]++;
                if (got.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                    n_errors++;
                end
                if (got.granted !== want.granted)
                begin
                    $error("granted_offset mismatch: expected %0h, got %0h",
                           want.granted, got.granted);
                    n_errors++;
                end
                if (got.free_space !== want.free_space)
                begin
                    $error("free_space mismatch: expected %0h, got %0h",
                           want.free_space, got.free_space);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence
    initial
    begin : main_seq
        addr_t phase_total [PHASES];
        phase_total  = '{32'd100, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000,
                         32'd4096, 32'd0, 32'd1000, 32'd65536};
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        n_errors     = 0;
        n_checked    = 0;
        n_settings   = 1;
        cycle_count  = 0;
        src_idle_pct = 18;
        snk_idle_pct = 50;
        for (int k = 0; k < 8; k++)
            status_seen[k] = 0;
        range_size = addr_t'(65536);
        rebuild_segments();

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed rows from the reset table
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_rows[i].cmd, dir_rows[i].req, dir_rows[i].off,
                      dir_rows[i].typed, dir_rows[i].want);

        // Random phases, one total_size setting each
        phase_total[6] = $urandom();
        for (int p = 0; p < PHASES; p++)
        begin
            src_idle_pct = (p < 3) ? 18 : (p < 6) ? 50 : 0;
            snk_idle_pct = (p < 3) ? 50 : (p < 6) ? 18 : 0;
            write_total(phase_total[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(phase_total[p] == addr_t'(1000));
        end

        wait_idle();
        if (expected_results.size() != 0)
        begin
            $error("%0d expected result words never arrived", expected_results.size());
            n_errors++;
        end

        $display("Checked %0d result words across %0d total_size settings.",
                 n_checked, n_settings);
        $display("Status counts: ok %0d, no space %0d, not found %0d, full %0d, zero %0d.",
                 status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_NOT_FOUND],
                 status_seen[ST_TABLE_FULL], status_seen[ST_ZERO_SIZE]);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
src/ffsa_pkg.sv
src/ffsa_alu.sv
src/ffsa_table.sv
src/first_fit_segment_allocator.sv
tb/tb_first_fit_segment_allocator.sv
